// ===== rtl/core/glpf_pkg.sv =====
// ============================================================================
// glpf_pkg
// Shared types and constants for the grid local peak finder.
// ============================================================================
package glpf_pkg;

   // parameter defaults
   localparam int MAX_COLS_DEF  = 32;
   localparam int MAX_ROWS_DEF  = 1024;
   localparam int DATA_BITS_DEF = 16;

   // fixed port widths
   localparam int SAMPLE_W    = 16;
   localparam int ROW_OUT_W   = 10;
   localparam int COL_OUT_W   = 5;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int ROWS_REG_W  = 11;
   localparam int COLS_REG_W  = 6;

   // grid size after reset, both dimensions
   localparam int GRID_RESET = 30;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_ROWS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_COLS = CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      ST_PRIME,   // issue read of the current column
      ST_LOAD,    // latch window, issue read of the right neighbor
      ST_RUN,     // stream samples
      ST_DRAIN,   // sweep the final row
      ST_FLUSH    // send the held result, tagged last
   } state_type;

   // neighbor presence for the comparison unit
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic has_right;
   } nbr_type;

   // comparison unit decisions
   typedef struct packed {
      logic peak_up;    // row above is a peak at this column
      logic peak_last;  // final-row entry is a peak
      logic flag_new;   // up and left checks pass for the new sample
   } judge_type;

endpackage

// ===== rtl/core/glpf_ram.sv =====
// ============================================================================
// glpf_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ============================================================================
module glpf_ram #(
   parameter int WIDTH  = 17,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/glpf_cmp.sv =====
// ============================================================================
// glpf_cmp
// Neighbor comparisons for one column: decision for the row above, decision
// for a final-row entry, and the up/left flag stored with a new sample.
// ============================================================================
module glpf_cmp import glpf_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic signed [DATA_BITS-1:0] sample,     // new sample, row below
   input  logic signed [DATA_BITS-1:0] prev,       // sample to the left
   input  logic signed [DATA_BITS-1:0] win_val,    // stored entry, this column
   input  logic                        win_flag,
   input  logic signed [DATA_BITS-1:0] right_val,  // stored entry, next column
   input  nbr_type                     nbr,
   output judge_type                   judge
);

   logic right_bigger;

   // horizontal right check of the stored entry; up/left already in win_flag
   assign right_bigger = nbr.has_right && (right_val > win_val);

   always_comb begin
      judge.peak_last = win_flag && !right_bigger;
      judge.peak_up   = !nbr.first_row && judge.peak_last && !(sample > win_val);
      judge.flag_new  = (nbr.first_row || !(win_val > sample)) &&
                        (nbr.first_col || !(prev > sample));
   end

endmodule

// ===== rtl/core/grid_local_peak_finder.sv =====
// ============================================================================
// grid_local_peak_finder
// Four-neighbor local maximum detection over a raster-scanned sample grid.
// ============================================================================
// Samples arrive in raster order, one per req transfer; each rsp transfer
// carries the row and column of a sample that is >= its up, down, left and
// right neighbors inside the grid. The decision for row r-1 column c is made
// on the transfer of sample (r,c); the last sample of the grid also releases
// the whole final row, so peaks leave in raster order and run_last marks the
// last peak caused by a sample. Inside a row one sample is taken per cycle
// while the rsp side is free. Each row end stalls req while the registered
// RAM read restarts at column 0 and column 1. The last sample of a grid is a
// row end too and is followed by the final-row sweep, which rsp stalls extend.
// After reset or a csr write the read is primed in the same way before the
// first sample is taken. No RAM clearing pass is needed.
// Grid size: csr index 0 = grid_rows, 1 = grid_cols; 0 acts as 1, values above
// MAX_ROWS / MAX_COLS saturate, and any write to either restarts the grid.
// ============================================================================
module grid_local_peak_finder import glpf_pkg::*; #(
   parameter int MAX_COLS  = MAX_COLS_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample_value,
   // peak output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ROW_OUT_W-1:0]   rsp_peak_row,
   output logic [COL_OUT_W-1:0]   rsp_peak_col,
   output logic                   rsp_run_last,
   // configuration writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int WORD_W = DATA_BITS + 1;   // {up/left flag, sample}

   localparam logic [ROW_W-1:0] RST_LAST_ROW =
      ROW_W'(((GRID_RESET > MAX_ROWS) ? MAX_ROWS : GRID_RESET) - 1);
   localparam logic [COL_W-1:0] RST_LAST_COL =
      COL_W'(((GRID_RESET > MAX_COLS) ? MAX_COLS : GRID_RESET) - 1);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [ROW_W-1:0] last_row_ff, last_row_in;   // grid_rows - 1, saturated
   logic [COL_W-1:0] last_col_ff, last_col_in;   // grid_cols - 1, saturated
   logic [ROW_W-1:0] row_pos_ff;
   logic [COL_W-1:0] col_pos_ff;                 // also sweep index in drain
   logic             drain_ff;                   // prime leads into the sweep

   // window: stored entry of the current column
   logic signed [DATA_BITS-1:0] win_val_ff;
   logic                        win_flag_ff;
   logic signed [DATA_BITS-1:0] prev_ff;         // previous sample, left nbr

   // held result, sent once we know whether another follows
   logic             pend_valid_ff;
   logic [ROW_W-1:0] pend_row_ff;
   logic [COL_W-1:0] pend_col_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic                 rsp_last_ff;

   // ---------------------------------------------------------------------
   // Configuration decode
   // ---------------------------------------------------------------------
   logic                  csr_hit;
   logic [ROWS_REG_W-1:0] rows_req;
   logic [COLS_REG_W-1:0] cols_req;
   logic [31:0]           rows_idx, cols_idx;

   assign csr_hit  = csr_write_en &&
                     (csr_index == REG_GRID_ROWS || csr_index == REG_GRID_COLS);
   assign rows_req = csr_wdata[ROWS_REG_W-1:0];
   assign cols_req = csr_wdata[COLS_REG_W-1:0];

   always_comb begin
      if (rows_req == '0) begin
         rows_idx = '0;
      end else if (32'(rows_req) > 32'(MAX_ROWS)) begin
         rows_idx = 32'(MAX_ROWS - 1);
      end else begin
         rows_idx = 32'(rows_req) - 32'd1;
      end
      if (cols_req == '0) begin
         cols_idx = '0;
      end else if (32'(cols_req) > 32'(MAX_COLS)) begin
         cols_idx = 32'(MAX_COLS - 1);
      end else begin
         cols_idx = 32'(cols_req) - 32'd1;
      end
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      if (csr_write_en && csr_index == REG_GRID_ROWS) begin
         last_row_in = rows_idx[ROW_W-1:0];
      end
      if (csr_write_en && csr_index == REG_GRID_COLS) begin
         last_col_in = cols_idx[COL_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Row store and comparison unit
   // ---------------------------------------------------------------------
   logic [DATA_BITS+SAMPLE_W-1:0] sample_wide;
   logic signed [DATA_BITS-1:0]   sample;
   logic [WORD_W-1:0]             ram_rd_data;
   logic signed [DATA_BITS-1:0]   right_val;
   logic [COL_W-1:0]              rd_addr;
   logic                          accept;
   nbr_type                       nbr;
   judge_type                     judge;

   // raw field masked to DATA_BITS and read as two's complement
   assign sample_wide = {{DATA_BITS{1'b0}}, req_sample_value};
   assign sample      = $signed(sample_wide[DATA_BITS-1:0]);
   assign right_val   = $signed(ram_rd_data[DATA_BITS-1:0]);
   assign accept      = req_valid && req_ready;

   // one entry per column; entry c holds row r-1 until sample (r,c) lands
   glpf_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (MAX_COLS),
      .ADDR_W (COL_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_pos_ff),
      .wr_data ({judge.flag_new, sample}),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign nbr.first_row = (row_pos_ff == '0);
   assign nbr.first_col = (col_pos_ff == '0);
   assign nbr.has_right = (col_pos_ff != last_col_ff);

   glpf_cmp #(
      .DATA_BITS (DATA_BITS)
   ) u_cmp (
      .sample    (sample),
      .prev      (prev_ff),
      .win_val   (win_val_ff),
      .win_flag  (win_flag_ff),
      .right_val (right_val),
      .nbr       (nbr),
      .judge     (judge)
   );

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   logic             out_free;
   logic             at_col_end, last_sample;
   logic             adv;            // column step in run or drain
   logic             out_load, out_last, out_from_pend;
   logic             pend_load, pend_clear, flush_done;
   logic [ROW_W-1:0] pk_row;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign at_col_end  = (col_pos_ff == last_col_ff);
   assign last_sample = at_col_end && (row_pos_ff == last_row_ff);
   assign pk_row      = (state_ff == ST_DRAIN) ? last_row_ff
                                               : row_pos_ff - ROW_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_PRIME: state_in = ST_LOAD;
         ST_LOAD:  state_in = drain_ff ? ST_DRAIN : ST_RUN;
         ST_RUN: begin
            if (accept && at_col_end) begin
               state_in = ST_PRIME;
            end
         end
         ST_DRAIN: begin
            if (adv && at_col_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (flush_done) begin
               state_in = ST_PRIME;
            end
         end
         default: state_in = ST_PRIME;
      endcase
      if (csr_hit) begin
         state_in = ST_PRIME;
      end
   end

   // control outputs
   always_comb begin
      req_ready     = 1'b0;
      adv           = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      out_from_pend = 1'b0;
      pend_load     = 1'b0;
      pend_clear    = 1'b0;
      flush_done    = 1'b0;
      // hold the right neighbor on the read port unless stepping
      rd_addr       = col_pos_ff + COL_W'(1);
      unique case (state_ff)
         ST_PRIME: rd_addr = col_pos_ff;
         ST_LOAD:  rd_addr = col_pos_ff + COL_W'(1);
         ST_RUN: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               adv     = 1'b1;
               rd_addr = col_pos_ff + COL_W'(2);
               if (judge.peak_up) begin
                  // on the last sample the final row may still follow
                  if (last_sample) begin
                     pend_load = 1'b1;
                  end else begin
                     out_load = 1'b1;
                     out_last = 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!(judge.peak_last && pend_valid_ff && !out_free)) begin
               adv     = 1'b1;
               rd_addr = col_pos_ff + COL_W'(2);
               if (judge.peak_last) begin
                  pend_load = 1'b1;
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     out_from_pend = 1'b1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            flush_done = !pend_valid_ff || out_free;
            if (pend_valid_ff && out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               out_from_pend = 1'b1;
               pend_clear    = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result coordinates into the fixed port widths
   logic [ROW_W-1:0]           out_row_src;
   logic [COL_W-1:0]           out_col_src;
   logic [ROW_W+ROW_OUT_W-1:0] row_wide;
   logic [COL_W+COL_OUT_W-1:0] col_wide;

   assign out_row_src = out_from_pend ? pend_row_ff : pk_row;
   assign out_col_src = out_from_pend ? pend_col_ff : col_pos_ff;
   assign row_wide    = {{ROW_OUT_W{1'b0}}, out_row_src};
   assign col_wide    = {{COL_OUT_W{1'b0}}, out_col_src};
   assign rsp_row_in  = row_wide[ROW_OUT_W-1:0];
   assign rsp_col_in  = col_wide[COL_OUT_W-1:0];

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_PRIME;
         last_row_ff   <= RST_LAST_ROW;
         last_col_ff   <= RST_LAST_COL;
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         drain_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         last_row_ff <= last_row_in;
         last_col_ff <= last_col_in;

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_hit) begin
            // restart the grid
            row_pos_ff    <= '0;
            col_pos_ff    <= '0;
            drain_ff      <= 1'b0;
            pend_valid_ff <= 1'b0;
         end else begin
            if (adv) begin
               if (at_col_end) begin
                  col_pos_ff <= '0;
               end else begin
                  col_pos_ff <= col_pos_ff + COL_W'(1);
               end
            end
            if (accept && at_col_end) begin
               if (last_sample) begin
                  row_pos_ff <= '0;
                  drain_ff   <= 1'b1;
               end else begin
                  row_pos_ff <= row_pos_ff + ROW_W'(1);
               end
            end
            if (flush_done) begin
               drain_ff <= 1'b0;
            end
            if (pend_load) begin
               pend_valid_ff <= 1'b1;
            end else if (pend_clear) begin
               pend_valid_ff <= 1'b0;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD || adv) begin
         win_val_ff  <= right_val;
         win_flag_ff <= ram_rd_data[DATA_BITS];
      end
      if (accept) begin
         prev_ff <= sample;
      end
      if (pend_load) begin
         pend_row_ff <= pk_row;
         pend_col_ff <= col_pos_ff;
      end
      if (out_load) begin
         rsp_row_ff  <= rsp_row_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_peak_row = rsp_row_ff;
   assign rsp_peak_col = rsp_col_ff;
   assign rsp_run_last = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // held result only lives through the final-row sweep
   a_pend_not_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !pend_valid_ff)
      else $error("held result present while streaming");

   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      col_pos_ff <= last_col_ff)
      else $error("column position beyond grid width");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      row_pos_ff <= last_row_ff)
      else $error("row position beyond grid height");

   // last sample of the grid starts the final-row sweep
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && last_sample && !csr_hit) |=> (drain_ff && state_ff == ST_PRIME))
      else $error("final row sweep not started");

endmodule

// ===== test/glpf_peak_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// glpf_peak_checker
// Watches the csr, req and rsp ports of the grid peak finder, keeps its own
// copy of the grid size and row stores, predicts the peaks of every accepted
// sample and compares each rsp transfer with the oldest predicted peak.
// ============================================================================
module glpf_peak_checker import glpf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [ROW_OUT_W-1:0]   rsp_peak_row,
   input  logic [COL_OUT_W-1:0]   rsp_peak_col,
   input  logic                   rsp_run_last,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     peaks_pending,
   output int                     mismatch_count
);

   localparam int LINE_LEN = MAX_COLS_DEF;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
   } peak_type;

   logic [ROWS_REG_W-1:0]      rows_reg;
   logic [COLS_REG_W-1:0]      cols_reg;
   logic signed [SAMPLE_W-1:0] line_up  [LINE_LEN];
   logic signed [SAMPLE_W-1:0] line_mid [LINE_LEN];
   logic signed [SAMPLE_W-1:0] line_new [LINE_LEN];
   int unsigned                row_at;
   int unsigned                col_at;
   peak_type                   peaks_due [$];
   peak_type                   want;
   int                         errors = 0;

   // zero acts as one, oversize saturates
   function automatic int unsigned grid_extent(input int unsigned raw, input int unsigned limit);
      return (raw == 0) ? 1 : ((raw > limit) ? limit : raw);
   endfunction

   function automatic bit is_peak(input logic signed [SAMPLE_W-1:0] v, up, down, left, right,
                                  input bit has_up, has_down, has_left, has_right);
      return !((has_up && up > v) || (has_down && down > v) ||
               (has_left && left > v) || (has_right && right > v));
   endfunction

   task automatic note_peak(input int unsigned r, input int unsigned c);
      peak_type hit;
      hit.row  = ROW_OUT_W'(r);
      hit.col  = COL_OUT_W'(c);
      hit.last = 1'b0;
      peaks_due.push_back(hit);
   endtask

   task automatic report_miss(input string what, input int want_v, input int got_v);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
   endtask

   // one accepted sample: decide the row above, and the final row on the last sample
   task automatic scan_sample(input logic [SAMPLE_W-1:0] raw);
      int unsigned nrows, ncols, r, c, k, lt, rt;
      int          first_new;
      peak_type    tail;
      nrows = grid_extent(rows_reg, MAX_ROWS_DEF);
      ncols = grid_extent(cols_reg, MAX_COLS_DEF);
      r = row_at;
      c = col_at;
      if (r >= nrows || c >= ncols) begin
         r = 0;
         c = 0;
      end
      line_new[c] = raw;
      first_new = peaks_due.size();
      lt = (c > 0) ? c - 1 : c;
      rt = (c + 1 < ncols) ? c + 1 : c;
      if (r >= 1 && is_peak(line_mid[c], line_up[c], line_new[c], line_mid[lt], line_mid[rt],
                            r >= 2, 1'b1, c > 0, c + 1 < ncols))
         note_peak(r - 1, c);
      if (c + 1 < ncols) begin
         col_at = c + 1;
         row_at = r;
      end else if (r + 1 < nrows) begin
         for (k = 0; k < LINE_LEN; k++) begin
            line_up[k]  = line_mid[k];
            line_mid[k] = line_new[k];
         end
         col_at = 0;
         row_at = r + 1;
      end else begin
         for (k = 0; k < ncols; k++) begin
            lt = (k > 0) ? k - 1 : k;
            rt = (k + 1 < ncols) ? k + 1 : k;
            if (is_peak(line_new[k], line_mid[k], '0, line_new[lt], line_new[rt],
                        r >= 1, 1'b0, k > 0, k + 1 < ncols))
               note_peak(r, k);
         end
         col_at = 0;
         row_at = 0;
      end
      if (peaks_due.size() > first_new) begin
         tail = peaks_due.pop_back();
         tail.last = 1'b1;
         peaks_due.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg = ROWS_REG_W'(GRID_RESET);
         cols_reg = COLS_REG_W'(GRID_RESET);
         row_at   = 0;
         col_at   = 0;
         peaks_due.delete();
      end else begin
         // any write to a real register restarts the grid
         if (csr_write_en) begin
            if (csr_index == REG_GRID_ROWS) begin
               rows_reg = csr_wdata[ROWS_REG_W-1:0];
               row_at   = 0;
               col_at   = 0;
            end else if (csr_index == REG_GRID_COLS) begin
               cols_reg = csr_wdata[COLS_REG_W-1:0];
               row_at   = 0;
               col_at   = 0;
            end
         end
         if (req_valid && req_ready)
            scan_sample(req_sample_value);
         if (rsp_valid && rsp_ready) begin
            if (peaks_due.size() == 0) begin
               errors++;
               $display("%0t: peak at row %0d col %0d, expected none", $time,
                        rsp_peak_row, rsp_peak_col);
            end else begin
               want = peaks_due.pop_front();
               if (rsp_peak_row !== want.row)
                  report_miss("peak_row", want.row, rsp_peak_row);
               if (rsp_peak_col !== want.col)
                  report_miss("peak_col", want.col, rsp_peak_col);
               if (rsp_run_last !== want.last)
                  report_miss("run_last", want.last, rsp_run_last);
            end
         end
      end
      peaks_pending  <= peaks_due.size();
      mismatch_count <= errors;
   end

endmodule

// ===== test/grid_local_peak_finder_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grid_local_peak_finder_tb
// Drives raster-ordered samples and grid-size writes into the peak finder
// with random idle on both channels; a checker beside the block predicts and
// compares every peak transfer. Verdict on the checker's mismatch count.
// ============================================================================
module grid_local_peak_finder_tb;
   import glpf_pkg::*;

   // indexes past the register list; writes there are ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = CSR_INDEX_W'(3);

   // padded over the longest final-row sweep for the quiet time
   localparam int SETTLE_CYCLES = MAX_COLS_DEF + 16;
   localparam int RANDOM_ITEMS  = 80;
   localparam int TALL_ITEMS    = 24;
   localparam int RESET_CYCLES  = 12;

   typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE, VAL_FLAT} value_mode_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [ROW_OUT_W-1:0]   rsp_peak_row;
   logic [COL_OUT_W-1:0]   rsp_peak_col;
   logic                   rsp_run_last;
   logic                   csr_write_en     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   int idle_pct = 36;      // percent of cycles each side sits idle
   int peaks_pending;
   int mismatch_count;
   int sent_random = 0;

   grid_local_peak_finder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_peak_row     (rsp_peak_row),
      .rsp_peak_col     (rsp_peak_col),
      .rsp_run_last     (rsp_run_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   glpf_peak_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_peak_row     (rsp_peak_row),
      .rsp_peak_col     (rsp_peak_col),
      .rsp_run_last     (rsp_run_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .peaks_pending    (peaks_pending),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, drawn fresh every cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);

   // grid size as the block sees it: zero acts as one, oversize saturates
   function automatic int grid_extent(input int raw, input int limit);
      return (raw == 0) ? 1 : ((raw > limit) ? limit : raw);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_value(input value_mode_type mode);
      case (mode)
         VAL_WIDE:   return SAMPLE_W'($urandom);
         VAL_NARROW: return SAMPLE_W'(int'($urandom_range(0, 4)) - 2);  // lots of ties
         VAL_EDGE: begin
            case ($urandom_range(0, 3))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               2:       return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default:    return 16'h5A5A;   // flat grid: every sample is a peak
      endcase
   endfunction

   // one sample transfer; valid is only dropped when an idle cycle is drawn
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and let every predicted peak come out
   task automatic wait_for_peaks();
      req_valid <= 1'b0;
      @(posedge clock);
      while (peaks_pending != 0) @(posedge clock);
   endtask

   // a sample may still be sweeping the final row with no peak to show for
   // it, so give the block its full latency before touching the registers
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int data);
      wait_for_peaks();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // count samples in raster order; optionally hold off mid-way until drained
   task automatic send_grid(input int count, input value_mode_type mode, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at && pause_at > 0)
            wait_for_peaks();
         send_sample(pick_value(mode));
      end
   endtask

   initial begin : stimulus
      int             nrows;
      int             ncols;
      int             size;
      int             part;
      int             chunk;
      value_mode_type mode;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----------------------------------------------------------
      // zero sizes act as a 1x1 grid: every sample is a peak and wraps the grid
      write_reg(REG_GRID_ROWS, 0);
      write_reg(REG_GRID_COLS, 0);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);

      // single row: no up or down neighbor, all peaks come on the last sample
      write_reg(REG_GRID_ROWS, 1);
      write_reg(REG_GRID_COLS, 4);
      send_sample(16'h8000);
      send_sample(16'h0005);
      send_sample(16'h0005);
      send_sample(16'hFFFF);

      // single column: no left or right neighbor, every sample ends a row
      write_reg(REG_GRID_ROWS, 4);
      write_reg(REG_GRID_COLS, 1);
      send_sample(16'h0003);
      send_sample(16'h0003);
      send_sample(16'hFFF9);
      send_sample(16'h7FFF);

      // 3x3 with writes past the register list in the middle: they must not
      // restart the grid
      write_reg(REG_GRID_ROWS, 3);
      write_reg(REG_GRID_COLS, 3);
      send_sample(16'h0001);
      send_sample(16'h0004);
      send_sample(16'h0004);
      send_sample(16'h0002);
      write_reg(REG_SPARE_LO, 11'h7FF);
      write_reg(REG_SPARE_HI, 11'h001);
      send_sample(16'h8000);
      send_sample(16'h0004);
      send_sample(16'h7FFF);
      send_sample(16'h7FFF);
      send_sample(16'h0000);

      // ---- register extremes ---------------------------------------------------
      // oversize rows saturate: the top rows of a tall single-column grid
      write_reg(REG_GRID_ROWS, 11'h7FF);
      write_reg(REG_GRID_COLS, 1);
      send_grid(TALL_ITEMS, VAL_NARROW, -1);

      // oversize cols saturate to 32; flat 2x32 gives the longest peak burst
      write_reg(REG_GRID_ROWS, 2);
      write_reg(REG_GRID_COLS, 63);
      send_grid(2 * MAX_COLS_DEF, VAL_FLAT, -1);

      // exact maximum of both registers, broken off after a few rows, run with
      // no idling at all
      idle_pct <= 0;
      write_reg(REG_GRID_ROWS, MAX_ROWS_DEF);
      write_reg(REG_GRID_COLS, MAX_COLS_DEF);
      send_grid(2 * MAX_COLS_DEF + 5, VAL_WIDE, MAX_COLS_DEF + 3);
      idle_pct <= 36;

      // ---- random grids --------------------------------------------------------
      // mostly complete grids with random content, some cut short by a write
      while (sent_random < RANDOM_ITEMS) begin
         nrows = $urandom_range(0, 4);
         ncols = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 63) : $urandom_range(0, 16);
         write_reg(REG_GRID_ROWS, nrows);
         // upper csr_wdata bits are don't-care for the column register
         write_reg(REG_GRID_COLS, int'($urandom << COLS_REG_W) | ncols);
         size = grid_extent(nrows, MAX_ROWS_DEF) * grid_extent(ncols, MAX_COLS_DEF);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: mode = VAL_NARROW;
            5, 6, 7:       mode = VAL_WIDE;
            8:             mode = VAL_EDGE;
            default:       mode = VAL_FLAT;
         endcase
         repeat ($urandom_range(1, 2)) begin
            chunk = (size < RANDOM_ITEMS - sent_random) ? size : RANDOM_ITEMS - sent_random;
            send_grid(chunk, mode, ($urandom_range(0, 3) == 0) ? chunk / 2 : -1);
            sent_random += chunk;
         end
         if (size > 1 && sent_random < RANDOM_ITEMS && $urandom_range(0, 3) == 0) begin
            part = $urandom_range(1, size - 1);
            if (part > RANDOM_ITEMS - sent_random)
               part = RANDOM_ITEMS - sent_random;
            send_grid(part, mode, -1);
            sent_random += part;
         end
      end

      // ---- wrap up -------------------------------------------------------------
      wait_for_peaks();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
